// File: hw/rtl/assert_macros.svh
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MRFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define MRFP_ASSERT_NEVER(lbl, cond, msg) \
  `MRFP_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/mrfp_pkg.sv
// types, constants and helpers of the meter reply frame parser
`default_nettype none

package mrfp_pkg;

  localparam int unsigned MAX_FRAC_DIGITS = 4;
  localparam int unsigned FRAC_W          = $clog2(10 ** MAX_FRAC_DIGITS);
  localparam int unsigned FRAC_CNT_W      = $clog2(MAX_FRAC_DIGITS + 1);

  localparam int unsigned NUM_W    = 32;
  localparam int unsigned GROUP_W  = 4;
  localparam int unsigned BCC_W    = 7;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned FDIG_W   = 3;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0d;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 7'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 7'h29;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
  localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2f;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

  typedef enum logic {
    KIND_VALUE  = 1'b0,
    KIND_STATUS = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_BAD_BCC   = 2'd2
  } frame_status_e;

  typedef enum logic {
    REPLY_IDENT = 1'b0,
    REPLY_DATA  = 1'b1
  } reply_kind_e;

  typedef struct packed {
    item_kind_e          item_kind;
    logic [NUM_W-1:0]    number;
    logic [FDIG_W-1:0]   frac_digits;
    logic [GROUP_W-1:0]  group_index;
    frame_status_e       frame_status;
    logic                final_item;
  } result_t;

  // results of one byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_pair_t;

  // ten to the n, for n up to the fraction digit limit
  function automatic logic [NUM_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
    logic [NUM_W-1:0] p;
    p = NUM_W'(1);
    for (int unsigned i = 0; i < MAX_FRAC_DIGITS; i++) begin
      if (FRAC_CNT_W'(i) < n) begin
        p = NUM_W'(p * NUM_W'(10));
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrfp_in_if.sv
// byte channel into the parser
`default_nettype none

interface mrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  logic       reply_kind;

  modport source (output valid, output rx_byte, output frame_end, output reply_kind,
                  input ready);
  modport sink (input valid, input rx_byte, input frame_end, input reply_kind,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mrfp_out_if.sv
// result channel out of the parser
`default_nettype none

interface mrfp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] number;
  logic [2:0]  frac_digits;
  logic [3:0]  group_index;
  logic [1:0]  frame_status;
  logic        final_item;

  modport source (output valid, output item_kind, output number, output frac_digits,
                  output group_index, output frame_status, output final_item,
                  input ready);
  modport sink (input valid, input item_kind, input number, input frac_digits,
                input group_index, input frame_status, input final_item,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/meter_reply_frame_parser.sv
// Meter reply frame parser: parses bracketed values and checks each frame.
// Flow: a byte accepted goes into the input register; when the result queue
//   has room it is parsed and its words are written into the queue and offered.
// Throughput: one byte per cycle while the queue has room; a byte may yield two
//   words, and input stalls while the four-word result queue has under two free.
// Reset: asynchronous, clears frame state and queue; the next byte starts a frame.
`default_nettype none

module meter_reply_frame_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mrfp_in_if.sink    in_i,
  mrfp_out_if.source out_o
);

  mrfp_pkg::res_pair_t pair;
  logic                space2;

  mrfp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .space2_i (space2),
    .pair_o   (pair)
  );

  mrfp_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair),
    .space2_o (space2),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mrfp_core.sv
// input register, per-byte frame state update and result formation
`default_nettype none
`include "assert_macros.svh"

module mrfp_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mrfp_in_if.sink            in_i,
  input  wire logic          space2_i,
  output mrfp_pkg::res_pair_t pair_o
);

  localparam int unsigned NW = mrfp_pkg::NUM_W;
  localparam int unsigned FW = mrfp_pkg::FRAC_W;
  localparam int unsigned CW = mrfp_pkg::FRAC_CNT_W;

  // input register
  logic                          vld_q;
  logic [mrfp_pkg::CHAR_W-1:0]   char_q;
  logic                          last_q;
  logic                          kind_q;

  // frame state
  logic                          at_start_q, at_start_d;
  logic                          first_ok_q, first_ok_d;
  logic [mrfp_pkg::BCC_W-1:0]    bcc_q, bcc_d;
  logic                          inside_q, inside_d;
  logic                          stopped_q, stopped_d;
  logic [NW-1:0]                 int_q, int_d;
  logic                          int_over_q, int_over_d;
  logic                          dot_q, dot_d;
  logic [CW-1:0]                 fchars_q, fchars_d;
  logic [FW-1:0]                 frac_q, frac_d;
  logic                          frac_over_q, frac_over_d;
  logic [mrfp_pkg::GROUP_W-1:0]  groups_q, groups_d;

  logic                          step;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic                          val_push;
  logic                          start_ok;
  mrfp_pkg::frame_status_e       status;
  mrfp_pkg::result_t             val_res;
  mrfp_pkg::result_t             stat_res;

  assign step     = vld_q && space2_i;
  assign in_i.ready = !vld_q || step;

  assign is_digit = (char_q >= mrfp_pkg::CH_ZERO) && (char_q <= mrfp_pkg::CH_NINE);
  assign digit    = 4'(char_q - mrfp_pkg::CH_ZERO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.rx_byte[mrfp_pkg::CHAR_W-1:0];
      last_q <= in_i.frame_end;
      kind_q <= in_i.reply_kind;
    end
  end

  always_comb begin
    at_start_d  = at_start_q;
    first_ok_d  = first_ok_q;
    bcc_d       = bcc_q;
    inside_d    = inside_q;
    stopped_d   = stopped_q;
    int_d       = int_q;
    int_over_d  = int_over_q;
    dot_d       = dot_q;
    fchars_d    = fchars_q;
    frac_d      = frac_q;
    frac_over_d = frac_over_q;
    groups_d    = groups_q;
    val_push    = 1'b0;

    if (step) begin
      if (at_start_q) begin
        first_ok_d = (char_q == mrfp_pkg::CH_SLASH);
        at_start_d = 1'b0;
      end else if (!last_q) begin
        bcc_d = mrfp_pkg::BCC_W'(bcc_q + char_q);
      end

      if (!stopped_q) begin
        if (!inside_q) begin
          if (char_q == mrfp_pkg::CH_OPEN) begin
            inside_d    = 1'b1;
            int_d       = '0;
            int_over_d  = 1'b0;
            dot_d       = 1'b0;
            fchars_d    = '0;
            frac_d      = '0;
            frac_over_d = 1'b0;
          end else if (char_q == mrfp_pkg::CH_NUL) begin
            stopped_d = 1'b1;
          end
        end else if (char_q == mrfp_pkg::CH_CLOSE) begin
          val_push = 1'b1;
          inside_d = 1'b0;
          if (groups_q != '1) begin
            groups_d = groups_q + mrfp_pkg::GROUP_W'(1);
          end
        end else if (char_q == mrfp_pkg::CH_CR || char_q == mrfp_pkg::CH_NUL) begin
          stopped_d = 1'b1;
          inside_d  = 1'b0;
        end else if (dot_q) begin
          if (fchars_q < CW'(mrfp_pkg::MAX_FRAC_DIGITS)) begin
            if (!frac_over_q) begin
              if (is_digit) begin
                frac_d = FW'(frac_q * FW'(10)) + FW'(digit);
              end else begin
                frac_over_d = 1'b1;
              end
            end
            fchars_d = fchars_q + CW'(1);
          end
        end else begin
          if (char_q == mrfp_pkg::CH_DOT) begin
            dot_d = 1'b1;
          end
          if (!int_over_q) begin
            if (is_digit) begin
              int_d = NW'(int_q * NW'(10)) + NW'(digit);
            end else begin
              int_over_d = 1'b1;
            end
          end
        end
      end

      // the last byte always closes the frame
      if (last_q) begin
        at_start_d  = 1'b1;
        first_ok_d  = 1'b0;
        bcc_d       = '0;
        inside_d    = 1'b0;
        stopped_d   = 1'b0;
        groups_d    = '0;
        int_d       = '0;
        int_over_d  = 1'b0;
        dot_d       = 1'b0;
        fchars_d    = '0;
        frac_d      = '0;
        frac_over_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q  <= 1'b1;
      first_ok_q  <= 1'b0;
      bcc_q       <= '0;
      inside_q    <= 1'b0;
      stopped_q   <= 1'b0;
      int_q       <= '0;
      int_over_q  <= 1'b0;
      dot_q       <= 1'b0;
      fchars_q    <= '0;
      frac_q      <= '0;
      frac_over_q <= 1'b0;
      groups_q    <= '0;
    end else begin
      at_start_q  <= at_start_d;
      first_ok_q  <= first_ok_d;
      bcc_q       <= bcc_d;
      inside_q    <= inside_d;
      stopped_q   <= stopped_d;
      int_q       <= int_d;
      int_over_q  <= int_over_d;
      dot_q       <= dot_d;
      fchars_q    <= fchars_d;
      frac_q      <= frac_d;
      frac_over_q <= frac_over_d;
      groups_q    <= groups_d;
    end
  end

  // a one-byte frame checks the start byte against itself
  assign start_ok = at_start_q ? (char_q == mrfp_pkg::CH_SLASH) : first_ok_q;

  always_comb begin
    if (kind_q == mrfp_pkg::REPLY_IDENT) begin
      status = start_ok ? mrfp_pkg::STATUS_OK : mrfp_pkg::STATUS_BAD_START;
    end else begin
      status = (char_q == (at_start_q ? '0 : bcc_q)) ? mrfp_pkg::STATUS_OK
                                                     : mrfp_pkg::STATUS_BAD_BCC;
    end
  end

  always_comb begin
    val_res.item_kind    = mrfp_pkg::KIND_VALUE;
    val_res.number       = NW'(int_q * mrfp_pkg::pow10(fchars_q)) + NW'(frac_q);
    val_res.frac_digits  = mrfp_pkg::FDIG_W'(fchars_q);
    val_res.group_index  = groups_q;
    val_res.frame_status = mrfp_pkg::STATUS_OK;
    val_res.final_item   = 1'b0;

    stat_res.item_kind    = mrfp_pkg::KIND_STATUS;
    stat_res.number       = '0;
    stat_res.frac_digits  = '0;
    stat_res.group_index  = '0;
    stat_res.frame_status = status;
    stat_res.final_item   = 1'b1;
  end

  always_comb begin
    pair_o.count  = 2'({1'b0, val_push} + {1'b0, step && last_q});
    pair_o.first  = val_push ? val_res : stat_res;
    pair_o.second = stat_res;
  end

  `MRFP_ASSERT(a_pair_order, (pair_o.count == 2'd2) |-> (pair_o.first.item_kind == mrfp_pkg::KIND_VALUE && pair_o.second.item_kind == mrfp_pkg::KIND_STATUS), "value word must precede status word")
  `MRFP_ASSERT(a_last_restarts, (step && last_q) |=> (at_start_q && !inside_q && !stopped_q), "frame not restarted after last byte")
  `MRFP_ASSERT_NEVER(a_stopped_outside, inside_q && stopped_q, "group open while parsing is stopped")
  `MRFP_ASSERT_NEVER(a_push_no_room, (pair_o.count != 2'd0) && !space2_i, "results pushed without queue room")

endmodule

`default_nettype wire

// File: hw/rtl/mrfp_out_fifo.sv
// result queue taking up to two words per cycle and giving one while the reader is ready
`default_nettype none
`include "assert_macros.svh"

module mrfp_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mrfp_pkg::res_pair_t pair_i,
  output logic               space2_o,
  mrfp_out_if.source         out_o
);

  localparam int unsigned PW = mrfp_pkg::OUT_PTR_W;
  localparam int unsigned NC = mrfp_pkg::OUT_CNT_W;

  mrfp_pkg::result_t mem_q [mrfp_pkg::OUT_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [NC-1:0]     cnt_q, cnt_d;
  logic              pop;
  mrfp_pkg::result_t head;

  assign space2_o = (cnt_q <= NC'(mrfp_pkg::OUT_DEPTH - 2));
  assign pop      = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = PW'(wr_ptr_q + PW'(pair_i.count));
    rd_ptr_d = pop ? PW'(rd_ptr_q + PW'(1)) : rd_ptr_q;
    cnt_d    = NC'(cnt_q + NC'(pair_i.count) - NC'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= pair_i.first;
    end
    if (pair_i.count == 2'd2) begin
      mem_q[PW'(wr_ptr_q + PW'(1))] <= pair_i.second;
    end
  end

  assign head = mem_q[rd_ptr_q];

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.item_kind    = head.item_kind;
  assign out_o.number       = head.number;
  assign out_o.frac_digits  = head.frac_digits;
  assign out_o.group_index  = head.group_index;
  assign out_o.frame_status = head.frame_status;
  assign out_o.final_item   = head.final_item;

  `MRFP_ASSERT_NEVER(a_no_overflow, cnt_q > NC'(mrfp_pkg::OUT_DEPTH), "result queue overflow")
  `MRFP_ASSERT(a_cnt_track, 1'b1 |=> (cnt_q == NC'($past(cnt_q) + NC'($past(pair_i.count)) - NC'($past(pop)))), "queue count out of step")
  `MRFP_ASSERT(a_ptr_gap, 1'b1 |-> (PW'(wr_ptr_q - rd_ptr_q) == PW'(cnt_q)), "queue pointers disagree with count")

endmodule

`default_nettype wire

// File: tb/sv/meter_reply_frame_parser_tb.sv
// testbench of the meter reply frame parser: directed and random frames against a byte-level predictor
module meter_reply_frame_parser_tb;

  localparam int unsigned RANDOM_BYTES = 1750;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0]            rx_byte;
    logic                  frame_end;
    mrfp_pkg::reply_kind_e reply_kind;
  } rx_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mrfp_in_if  byte_in ();
  mrfp_out_if word_out ();

  meter_reply_frame_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_in),
    .out_o  (word_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rx_word_t          pending_q[$];
  mrfp_pkg::result_t reply_words_q[$];
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;
  int unsigned frames_made = 0;
  int unsigned values_seen = 0;
  int unsigned status_seen [3];
  logic        quiet;

  // no idling on either side in this window
  assign quiet = (cycle_count >= 600) && (cycle_count < 1400);

  // predictor state, one frame at a time
  logic        fr_at_start;
  logic        fr_start_ok;
  logic [6:0]  fr_bcc;
  logic        fr_in_group;
  logic        fr_halted;
  logic [31:0] grp_int;
  logic        grp_int_done;
  logic        grp_dot;
  logic [2:0]  grp_frac_cnt;
  logic [13:0] grp_frac;
  logic        grp_frac_done;
  logic [3:0]  fr_group;

  function automatic void clear_value();
    grp_int       = '0;
    grp_int_done  = 1'b0;
    grp_dot       = 1'b0;
    grp_frac_cnt  = '0;
    grp_frac      = '0;
    grp_frac_done = 1'b0;
  endfunction

  function automatic void restart_frame();
    fr_at_start = 1'b1;
    fr_start_ok = 1'b0;
    fr_bcc      = '0;
    fr_in_group = 1'b0;
    fr_halted   = 1'b0;
    fr_group    = '0;
    clear_value();
  endfunction

  function automatic void parse_reply_byte(rx_word_t w);
    logic [6:0]              ch;
    logic                    first;
    logic                    digit;
    logic [31:0]             scaled;
    mrfp_pkg::frame_status_e st;
    mrfp_pkg::result_t       r;
    ch    = w.rx_byte[6:0];
    first = fr_at_start;
    digit = (ch >= mrfp_pkg::CH_ZERO) && (ch <= mrfp_pkg::CH_NINE);
    if (first) begin
      fr_start_ok = (ch == mrfp_pkg::CH_SLASH);
      fr_at_start = 1'b0;
    end else if (!w.frame_end) begin
      fr_bcc = fr_bcc + ch;
    end
    if (!fr_halted) begin
      if (!fr_in_group) begin
        if (ch == mrfp_pkg::CH_OPEN) begin
          fr_in_group = 1'b1;
          clear_value();
        end else if (ch == mrfp_pkg::CH_NUL) begin
          fr_halted = 1'b1;
        end
      end else if (ch == mrfp_pkg::CH_CLOSE) begin
        scaled = grp_int;
        for (int i = 0; i < grp_frac_cnt; i++) scaled = scaled * 32'd10;
        scaled = scaled + 32'(grp_frac);
        r              = '0;
        r.item_kind    = mrfp_pkg::KIND_VALUE;
        r.number       = scaled;
        r.frac_digits  = grp_frac_cnt;
        r.group_index  = fr_group;
        r.frame_status = mrfp_pkg::STATUS_OK;
        r.final_item   = 1'b0;
        reply_words_q.push_back(r);
        if (fr_group != 4'd15) fr_group = fr_group + 4'd1;
        fr_in_group = 1'b0;
      end else if (ch == mrfp_pkg::CH_CR || ch == mrfp_pkg::CH_NUL) begin
        fr_halted   = 1'b1;
        fr_in_group = 1'b0;
      end else if (grp_dot) begin
        // only the first four characters after the dot count
        if (grp_frac_cnt < mrfp_pkg::MAX_FRAC_DIGITS) begin
          if (!grp_frac_done) begin
            if (digit) grp_frac = 14'(grp_frac * 14'd10 + 14'(ch - mrfp_pkg::CH_ZERO));
            else grp_frac_done = 1'b1;
          end
          grp_frac_cnt = grp_frac_cnt + 3'd1;
        end
      end else begin
        if (ch == mrfp_pkg::CH_DOT) grp_dot = 1'b1;
        if (!grp_int_done) begin
          if (digit) grp_int = grp_int * 32'd10 + 32'(ch - mrfp_pkg::CH_ZERO);
          else grp_int_done = 1'b1;
        end
      end
    end
    if (w.frame_end) begin
      if (w.reply_kind == mrfp_pkg::REPLY_IDENT) begin
        st = fr_start_ok ? mrfp_pkg::STATUS_OK : mrfp_pkg::STATUS_BAD_START;
      end else begin
        st = (ch == (first ? mrfp_pkg::CH_NUL : fr_bcc)) ? mrfp_pkg::STATUS_OK
                                                         : mrfp_pkg::STATUS_BAD_BCC;
      end
      r              = '0;
      r.item_kind    = mrfp_pkg::KIND_STATUS;
      r.frame_status = st;
      r.final_item   = 1'b1;
      reply_words_q.push_back(r);
      restart_frame();
    end
  endfunction

  // frame builder
  string       addr_chars = "0123456789.:*-_ABCkWhV!";
  int unsigned gen_len = 0;
  logic [6:0]  gen_bcc = '0;

  function automatic void send_char(logic [6:0] ch);
    rx_word_t w;
    w.rx_byte    = {1'($urandom_range(0, 1)), ch};
    w.frame_end  = 1'b0;
    w.reply_kind = mrfp_pkg::reply_kind_e'($urandom_range(0, 1));
    pending_q.push_back(w);
    if (gen_len != 0) gen_bcc = gen_bcc + ch;
    gen_len++;
  endfunction

  function automatic void send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(7'(s[i]));
  endfunction

  function automatic void send_digits(int unsigned n);
    repeat (n) send_char(7'(mrfp_pkg::CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic logic [6:0] bcc_byte();
    return (gen_len == 0) ? mrfp_pkg::CH_NUL : gen_bcc;
  endfunction

  function automatic void end_frame(mrfp_pkg::reply_kind_e kind, logic [6:0] ch);
    rx_word_t w;
    w.rx_byte    = {1'($urandom_range(0, 1)), ch};
    w.frame_end  = 1'b1;
    w.reply_kind = kind;
    pending_q.push_back(w);
    gen_len = 0;
    gen_bcc = '0;
    frames_made++;
  endfunction

  function automatic logic [6:0] noise_char();
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(1, 127));
    return 7'(addr_chars[$urandom_range(0, addr_chars.len() - 1)]);
  endfunction

  function automatic void add_random_frame();
    mrfp_pkg::reply_kind_e kind;
    int unsigned           n_groups;
    kind = mrfp_pkg::reply_kind_e'($urandom_range(0, 1));
    // now and then a frame of pure line noise
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(0, 6)) send_char(7'($urandom_range(0, 127)));
      end_frame(kind, 7'($urandom_range(0, 127)));
      return;
    end
    if ($urandom_range(0, 9) == 0) send_char(noise_char());
    else if (kind == mrfp_pkg::REPLY_IDENT) send_char(mrfp_pkg::CH_SLASH);
    else send_char($urandom_range(0, 1) ? 7'h02 : 7'h01);
    n_groups = ($urandom_range(0, 24) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 4);
    repeat (n_groups) begin
      repeat ($urandom_range(0, 3)) send_char(noise_char());
      send_char(mrfp_pkg::CH_OPEN);
      send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3));
      if ($urandom_range(0, 9) < 7) begin
        send_char(mrfp_pkg::CH_DOT);
        send_digits($urandom_range(0, 6));
      end
      case ($urandom_range(0, 39))
        0:       send_char(mrfp_pkg::CH_CR);
        1:       send_char(mrfp_pkg::CH_NUL);
        2, 3, 4: send_char(noise_char());
        default: ;
      endcase
      if ($urandom_range(0, 29) != 0) send_char(mrfp_pkg::CH_CLOSE);
    end
    if ($urandom_range(0, 1)) begin
      send_char(7'h21);
      send_char(mrfp_pkg::CH_CR);
      send_char(7'h0a);
      send_char(7'h03);
    end
    case ($urandom_range(0, 19))
      0: begin
        // the closing bracket is also the last word of the frame
        send_char(mrfp_pkg::CH_OPEN);
        send_digits($urandom_range(0, 4));
        end_frame(kind, mrfp_pkg::CH_CLOSE);
      end
      1:       end_frame(kind, 7'($urandom_range(0, 127)));
      default: end_frame(kind, (kind == mrfp_pkg::REPLY_DATA) ? bcc_byte() : 7'h0a);
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    rx_word_t cur;
    rx_word_t nxt;
    if (!rst_ni) begin
      byte_in.valid      <= 1'b0;
      byte_in.rx_byte    <= '0;
      byte_in.frame_end  <= 1'b0;
      byte_in.reply_kind <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        cur.rx_byte    = byte_in.rx_byte;
        cur.frame_end  = byte_in.frame_end;
        cur.reply_kind = mrfp_pkg::reply_kind_e'(byte_in.reply_kind);
        parse_reply_byte(cur);
      end
      if (!byte_in.valid || byte_in.ready) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
          nxt = pending_q.pop_front();
          byte_in.valid      <= 1'b1;
          byte_in.rx_byte    <= nxt.rx_byte;
          byte_in.frame_end  <= nxt.frame_end;
          byte_in.reply_kind <= nxt.reply_kind;
        end else begin
          byte_in.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch_words
    mrfp_pkg::result_t got;
    mrfp_pkg::result_t want;
    if (!rst_ni) begin
      word_out.ready <= 1'b0;
    end else begin
      if (word_out.valid && word_out.ready) begin
        got.item_kind    = mrfp_pkg::item_kind_e'(word_out.item_kind);
        got.number       = word_out.number;
        got.frac_digits  = word_out.frac_digits;
        got.group_index  = word_out.group_index;
        got.frame_status = mrfp_pkg::frame_status_e'(word_out.frame_status);
        got.final_item   = word_out.final_item;
        if (reply_words_q.size() == 0) begin
          mismatches++;
          $display("%0t: no word expected, got %h", $time, got);
        end else begin
          want = reply_words_q.pop_front();
          check_field("item_kind", want.item_kind, got.item_kind);
          check_field("number", want.number, got.number);
          check_field("frac_digits", want.frac_digits, got.frac_digits);
          check_field("group_index", want.group_index, got.group_index);
          check_field("frame_status", want.frame_status, got.frame_status);
          check_field("final_item", want.final_item, got.final_item);
          if (want.item_kind == mrfp_pkg::KIND_VALUE) values_seen++;
          else status_seen[int'(want.frame_status)]++;
        end
      end
      word_out.ready <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL meter_reply_frame_parser");
      $finish;
    end
  end

  initial begin
    restart_frame();

    // identification reply whose last word closes a group
    send_text("/(1.5");
    end_frame(mrfp_pkg::REPLY_IDENT, mrfp_pkg::CH_CLOSE);
    // one-word data reply, checked against a zero sum
    end_frame(mrfp_pkg::REPLY_DATA, mrfp_pkg::CH_NUL);
    // fraction longer than the digit limit, good checksum
    send_char(7'h02);
    send_text("(3.12345)");
    end_frame(mrfp_pkg::REPLY_DATA, bcc_byte());
    // bad start, bracket and later dot inside a group, cr halts parsing
    send_text("X(.(1.)(5");
    send_char(mrfp_pkg::CH_CR);
    end_frame(mrfp_pkg::REPLY_IDENT, mrfp_pkg::CH_CLOSE);
    // top character, group left open, bad checksum
    send_char(7'h7f);
    send_char(mrfp_pkg::CH_OPEN);
    end_frame(mrfp_pkg::REPLY_DATA, 7'h39);

    while (pending_q.size() < RANDOM_BYTES) add_random_frame();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || byte_in.valid) @(posedge clk_i);
    while (reply_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d frames with %0d bracketed values", frames_made, values_seen);
    $display("frame status ok %0d, bad start %0d, bad checksum %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (mismatches == 0) begin
      $display("PASS meter_reply_frame_parser");
    end else begin
      $display("FAIL meter_reply_frame_parser");
    end
    $finish;
  end

endmodule

// File: meter_reply_frame_parser.f
+incdir+hw/rtl
hw/rtl/mrfp_pkg.sv
hw/rtl/mrfp_in_if.sv
hw/rtl/mrfp_out_if.sv
hw/rtl/mrfp_core.sv
hw/rtl/mrfp_out_fifo.sv
hw/rtl/meter_reply_frame_parser.sv
tb/sv/meter_reply_frame_parser_tb.sv
